### rtl/scan_outlier_segment_filter_unit_macros.svh
// Assertion macros shared by the scan outlier segment filter RTL.
`ifndef SCAN_OUTLIER_SEGMENT_FILTER_UNIT_MACROS_SVH
`define SCAN_OUTLIER_SEGMENT_FILTER_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, checked out of reset
`define SOSF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked out of reset
`define SOSF_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SOSF_ASSERT_IMP(lbl, ante, cons, msg)
`define SOSF_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

### rtl/sosf_pkg.sv
// Shared types and constants for the scan outlier segment filter.
package sosf_pkg;

    localparam int RANGE_W    = 16;
    localparam int LEN_W      = 5;
    localparam int WIN_W      = 12;
    localparam int COUNT_W    = 13;
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;

    localparam int PENDING_DEPTH_DEF   = 32;
    localparam int MAX_SCAN_POINTS_DEF = 4096;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // Register reset values
    localparam logic [RANGE_W-1:0] RANGE_MIN_RST  = 16'd0;
    localparam logic [RANGE_W-1:0] RANGE_MAX_RST  = 16'd65535;
    localparam logic [RANGE_W-1:0] JUMP_THR_RST   = 16'd100;
    localparam logic [LEN_W-1:0]   MIN_SEG_RST    = 5'd4;
    localparam logic [WIN_W-1:0]   WIN_FIRST_RST  = 12'd0;
    localparam logic [WIN_W-1:0]   WIN_LAST_RST   = 12'd4095;

    // Register index, taken from paddr word address
    typedef enum logic [2:0] {
        CFG_RANGE_MIN   = 3'd0,
        CFG_RANGE_MAX   = 3'd1,
        CFG_JUMP_THR    = 3'd2,
        CFG_MIN_SEG     = 3'd3,
        CFG_WIN_FIRST   = 3'd4,
        CFG_WIN_LAST    = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic [RANGE_W-1:0] range_min_mm;
        logic [RANGE_W-1:0] range_max_mm;
        logic [RANGE_W-1:0] jump_threshold_mm;
        logic [LEN_W-1:0]   min_segment_len;
        logic [WIN_W-1:0]   window_first;
        logic [WIN_W-1:0]   window_last;
    } cfg_t;

    // One pending buffer entry
    typedef struct packed {
        logic               ok;
        logic [RANGE_W-1:0] range_mm;
    } pend_entry_t;

endpackage

### rtl/sosf_in_if.sv
// Sample channel: one range sample per transfer.
interface sosf_in_if;
    import sosf_pkg::*;

    logic               valid;
    logic               ready;
    logic [RANGE_W-1:0] range_mm;
    logic               scan_end;

    modport source (output valid, output range_mm, output scan_end, input ready);
    modport sink   (input valid, input range_mm, input scan_end, output ready);
endinterface

### rtl/sosf_out_if.sv
// Result channel: one released sample per transfer.
interface sosf_out_if;
    import sosf_pkg::*;

    logic               valid;
    logic               ready;
    logic [RANGE_W-1:0] out_range_mm;
    logic               sample_ok;
    logic               run_last;
    logic               scan_done;
    logic               overflow;

    modport source (output valid, output out_range_mm, output sample_ok, output run_last,
                    output scan_done, output overflow, input ready);
    modport sink   (input valid, input out_range_mm, input sample_ok, input run_last,
                    input scan_done, input overflow, output ready);
endinterface

### rtl/sosf_cfg_regs.sv
// APB-style configuration register bank.
module sosf_cfg_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [sosf_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [sosf_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [sosf_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready,
    output sosf_pkg::cfg_t                  cfg
);
    import sosf_pkg::*;

    cfg_t     cfg_reg;
    cfg_idx_t reg_idx;
    logic     wr_en;

    assign pready  = 1'b1;
    assign reg_idx = cfg_idx_t'(paddr[CFG_ADDR_W-1:2]);
    assign wr_en   = psel && penable && pwrite;
    assign cfg     = cfg_reg;

    // Write the addressed register on the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.range_min_mm      <= RANGE_MIN_RST;
            cfg_reg.range_max_mm      <= RANGE_MAX_RST;
            cfg_reg.jump_threshold_mm <= JUMP_THR_RST;
            cfg_reg.min_segment_len   <= MIN_SEG_RST;
            cfg_reg.window_first      <= WIN_FIRST_RST;
            cfg_reg.window_last       <= WIN_LAST_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                CFG_RANGE_MIN: cfg_reg.range_min_mm      <= pwdata[RANGE_W-1:0];
                CFG_RANGE_MAX: cfg_reg.range_max_mm      <= pwdata[RANGE_W-1:0];
                CFG_JUMP_THR:  cfg_reg.jump_threshold_mm <= pwdata[RANGE_W-1:0];
                CFG_MIN_SEG:   cfg_reg.min_segment_len   <= pwdata[LEN_W-1:0];
                CFG_WIN_FIRST: cfg_reg.window_first      <= pwdata[WIN_W-1:0];
                CFG_WIN_LAST:  cfg_reg.window_last       <= pwdata[WIN_W-1:0];
                default: ;
            endcase
        end
    end

    // Return the addressed register, zero above the list
    always_comb
    begin
        unique case (reg_idx)
            CFG_RANGE_MIN: prdata = CFG_DATA_W'(cfg_reg.range_min_mm);
            CFG_RANGE_MAX: prdata = CFG_DATA_W'(cfg_reg.range_max_mm);
            CFG_JUMP_THR:  prdata = CFG_DATA_W'(cfg_reg.jump_threshold_mm);
            CFG_MIN_SEG:   prdata = CFG_DATA_W'(cfg_reg.min_segment_len);
            CFG_WIN_FIRST: prdata = CFG_DATA_W'(cfg_reg.window_first);
            CFG_WIN_LAST:  prdata = CFG_DATA_W'(cfg_reg.window_last);
            default:       prdata = '0;
        endcase
    end

endmodule

### rtl/scan_outlier_segment_filter_unit.sv
// Top level of the scan outlier and short-segment filter.
// Range samples inside the index window are held back by one and judged
// against their raw successor; each judged sample goes into a pending FIFO
// held in a single synchronous RAM (PENDING_DEPTH entries, one read and one
// write port, registered read). A jump over the threshold, or the end of the
// scan, releases the whole pending segment. A sample that causes no release
// passes through accept and decide; storing the held sample adds a push step,
// a release from a full buffer adds an overflow step, and a segment release
// opens the RAM read and then releases one entry per step, so a drain runs at
// one result per cycle while the result side takes them. The RAM needs no
// clearing after reset: only entries written since reset are ever read.
`include "scan_outlier_segment_filter_unit_macros.svh"

module scan_outlier_segment_filter_unit #(
    parameter int PENDING_DEPTH   = sosf_pkg::PENDING_DEPTH_DEF,
    parameter int MAX_SCAN_POINTS = sosf_pkg::MAX_SCAN_POINTS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    sosf_in_if.sink                         samples,
    sosf_out_if.source                      results,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [sosf_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [sosf_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [sosf_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready
);
    import sosf_pkg::*;

    localparam int PTR_W  = $clog2(PENDING_DEPTH);
    localparam int FILL_W = $clog2(PENDING_DEPTH + 1);
    localparam int IDX_W  = $clog2(MAX_SCAN_POINTS);
    localparam int CMP_W  = (IDX_W > WIN_W) ? IDX_W : WIN_W;

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_PLAN     = 6'b000010,
        S_PUSH     = 6'b000100,
        S_OVF      = 6'b001000,
        S_FLUSH_RD = 6'b010000,
        S_FLUSH    = 6'b100000
    } fsm_state_t;

    cfg_t cfg;

    // Control state
    fsm_state_t         state_reg, state_next;
    logic [RANGE_W-1:0] held_reg, held_next;
    logic               held_vld_reg, held_vld_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [PTR_W-1:0]   head_reg, head_next;
    logic [PTR_W-1:0]   tail_reg, tail_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic               kept_reg, kept_next;
    logic               end_reg, end_next;
    logic               phase_reg, phase_next;
    logic               flush1_reg, flush1_next;
    logic               keep1_reg, keep1_next;
    logic               end_push_reg, end_push_next;
    logic               out_valid_reg, out_valid_next;

    // Payload state
    logic [RANGE_W-1:0] x_reg, x_next;
    pend_entry_t        push_val_reg, push_val_next;
    pend_entry_t        end_entry_reg, end_entry_next;
    pend_entry_t        out_entry_reg;
    logic               out_last_reg, out_done_reg, out_ovf_reg;

    // Pending buffer RAM
    pend_entry_t        pend_mem [PENDING_DEPTH];
    pend_entry_t        mem_q;
    logic               rd_en, wr_en;
    logic [PTR_W-1:0]   rd_addr;

    // Result launch
    logic               emit;
    logic               emit_ok, emit_last, emit_done, emit_ovf;

    // Decision helpers
    logic [CMP_W-1:0]   idx_ext;
    logic               kept_now, end_now;
    logic               held_ok, x_ok, jump;
    logic [RANGE_W-1:0] diff;
    logic               slot_free, full, push1;
    logic [PTR_W-1:0]   head_inc, tail_inc;
    pend_entry_t        end_entry_c;
    logic               end_push_c;

    sosf_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Window and end-of-scan check on the incoming sample
    assign idx_ext  = CMP_W'(idx_reg);
    assign kept_now = (idx_ext >= CMP_W'(cfg.window_first))
                      && (idx_ext <= CMP_W'(cfg.window_last));
    assign end_now  = samples.scan_end || (kept_now && (idx_ext == CMP_W'(cfg.window_last)));

    // Range and jump tests on the held sample and its successor
    assign held_ok = (held_reg >= cfg.range_min_mm) && (held_reg <= cfg.range_max_mm);
    assign x_ok    = (x_reg >= cfg.range_min_mm) && (x_reg <= cfg.range_max_mm);
    assign diff    = (held_reg > x_reg) ? (held_reg - x_reg) : (x_reg - held_reg);
    assign jump    = diff > cfg.jump_threshold_mm;
    assign push1   = kept_reg && held_vld_reg;

    assign end_entry_c = kept_reg ? pend_entry_t'{ok: x_ok, range_mm: x_reg}
                                  : pend_entry_t'{ok: held_ok, range_mm: held_reg};
    assign end_push_c  = kept_reg || held_vld_reg;

    // FIFO pointers
    assign full      = (fill_reg == FILL_W'(PENDING_DEPTH));
    assign head_inc  = (head_reg == PTR_W'(PENDING_DEPTH - 1)) ? '0 : head_reg + PTR_W'(1);
    assign tail_inc  = (tail_reg == PTR_W'(PENDING_DEPTH - 1)) ? '0 : tail_reg + PTR_W'(1);
    assign slot_free = !out_valid_reg || results.ready;

    assign samples.ready = (state_reg == S_IDLE);

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        held_next      = held_reg;
        held_vld_next  = held_vld_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        fill_next      = fill_reg;
        kept_next      = kept_reg;
        end_next       = end_reg;
        phase_next     = phase_reg;
        flush1_next    = flush1_reg;
        keep1_next     = keep1_reg;
        end_push_next  = end_push_reg;
        x_next         = x_reg;
        push_val_next  = push_val_reg;
        end_entry_next = end_entry_reg;
        rd_en          = 1'b0;
        rd_addr        = head_reg;
        wr_en          = 1'b0;
        emit           = 1'b0;
        emit_ok        = mem_q.ok;
        emit_last      = 1'b0;
        emit_done      = 1'b0;
        emit_ovf       = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (samples.valid)
                begin
                    x_next    = samples.range_mm;
                    kept_next = kept_now;
                    end_next  = end_now;
                    if (end_now)
                        idx_next = '0;
                    else if (idx_reg != IDX_W'(MAX_SCAN_POINTS - 1))
                        idx_next = idx_reg + IDX_W'(1);
                    if (kept_now || end_now)
                        state_next = S_PLAN;
                end
            end

            S_PLAN:
            begin
                // Judge the held sample against its successor
                flush1_next    = 1'b0;
                keep1_next     = 1'b1;
                push_val_next  = '{ok: held_ok, range_mm: held_reg};
                end_entry_next = end_entry_c;
                end_push_next  = end_push_c;
                phase_next     = 1'b0;
                if (push1 && held_ok)
                begin
                    if (!jump)
                    begin
                        if (count_reg != COUNT_MAX)
                            count_next = count_reg + COUNT_W'(1);
                    end
                    else
                    begin
                        flush1_next = 1'b1;
                        keep1_next  = (count_reg >= COUNT_W'(cfg.min_segment_len));
                        count_next  = (count_reg >= COUNT_W'(cfg.min_segment_len))
                                      ? COUNT_W'(1) : '0;
                    end
                end
                if (kept_reg)
                begin
                    held_next     = x_reg;
                    held_vld_next = 1'b1;
                end
                if (end_reg)
                begin
                    held_next     = '0;
                    held_vld_next = 1'b0;
                    count_next    = '0;
                end
                if (push1)
                    state_next = S_PUSH;
                else if (end_reg)
                begin
                    phase_next    = 1'b1;
                    push_val_next = end_entry_c;
                    state_next    = end_push_c ? S_PUSH : S_FLUSH_RD;
                end
                else
                    state_next = S_IDLE;
            end

            S_PUSH, S_OVF:
            begin
                if (state_reg == S_PUSH && full)
                begin
                    // Fetch the oldest entry before it is pushed out
                    rd_en      = 1'b1;
                    state_next = S_OVF;
                end
                else if (state_reg == S_PUSH || slot_free)
                begin
                    if (state_reg == S_OVF)
                    begin
                        emit      = 1'b1;
                        emit_ovf  = 1'b1;
                        emit_last = !phase_reg && !flush1_reg && !end_reg;
                        head_next = head_inc;
                    end
                    else
                        fill_next = fill_reg + FILL_W'(1);
                    wr_en     = 1'b1;
                    tail_next = tail_inc;
                    // Advance to the next step of this item
                    if (phase_reg)
                        state_next = S_FLUSH_RD;
                    else if (flush1_reg)
                        state_next = S_FLUSH_RD;
                    else if (end_reg)
                    begin
                        phase_next    = 1'b1;
                        push_val_next = end_entry_reg;
                        state_next    = end_push_reg ? S_PUSH : S_FLUSH_RD;
                    end
                    else
                        state_next = S_IDLE;
                end
            end

            S_FLUSH_RD:
            begin
                if (fill_reg == '0)
                    state_next = S_IDLE;
                else
                begin
                    rd_en      = 1'b1;
                    state_next = S_FLUSH;
                end
            end

            S_FLUSH:
            begin
                if (slot_free)
                begin
                    // Release one entry and prefetch the next
                    emit      = 1'b1;
                    emit_ok   = (phase_reg || keep1_reg) && mem_q.ok;
                    emit_last = (fill_reg == FILL_W'(1)) && (phase_reg || !end_reg);
                    emit_done = (fill_reg == FILL_W'(1)) && phase_reg;
                    head_next = head_inc;
                    fill_next = fill_reg - FILL_W'(1);
                    if (fill_reg != FILL_W'(1))
                    begin
                        rd_en   = 1'b1;
                        rd_addr = head_inc;
                    end
                    else if (!phase_reg && end_reg)
                    begin
                        phase_next    = 1'b1;
                        push_val_next = end_entry_reg;
                        state_next    = end_push_reg ? S_PUSH : S_FLUSH_RD;
                    end
                    else
                        state_next = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    // Output register: load on release, drop on transfer
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
            out_valid_next = 1'b1;
        else if (results.ready)
            out_valid_next = 1'b0;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            held_reg      <= '0;
            held_vld_reg  <= 1'b0;
            count_reg     <= '0;
            idx_reg       <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            fill_reg      <= '0;
            kept_reg      <= 1'b0;
            end_reg       <= 1'b0;
            phase_reg     <= 1'b0;
            flush1_reg    <= 1'b0;
            keep1_reg     <= 1'b0;
            end_push_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            held_reg      <= held_next;
            held_vld_reg  <= held_vld_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            fill_reg      <= fill_next;
            kept_reg      <= kept_next;
            end_reg       <= end_next;
            phase_reg     <= phase_next;
            flush1_reg    <= flush1_next;
            keep1_reg     <= keep1_next;
            end_push_reg  <= end_push_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        x_reg         <= x_next;
        push_val_reg  <= push_val_next;
        end_entry_reg <= end_entry_next;
        if (emit)
        begin
            out_entry_reg <= '{ok: emit_ok, range_mm: mem_q.range_mm};
            out_last_reg  <= emit_last;
            out_done_reg  <= emit_done;
            out_ovf_reg   <= emit_ovf;
        end
    end

    // Pending buffer RAM, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
            pend_mem[tail_reg] <= push_val_reg;
        if (rd_en)
            mem_q <= pend_mem[rd_addr];
    end

    assign results.valid        = out_valid_reg;
    assign results.out_range_mm = out_entry_reg.range_mm;
    assign results.sample_ok    = out_entry_reg.ok;
    assign results.run_last     = out_last_reg;
    assign results.scan_done    = out_done_reg;
    assign results.overflow     = out_ovf_reg;

    `SOSF_ASSERT_IMP(a_fill_bound, 1'b1, fill_reg <= FILL_W'(PENDING_DEPTH), "pending fill above depth")
    `SOSF_ASSERT_IMP(a_empty_ptrs, fill_reg == '0, head_reg == tail_reg, "empty FIFO with split pointers")
    `SOSF_ASSERT_IMP(a_no_rw_clash, rd_en, !wr_en, "RAM read and write in one cycle")
    `SOSF_ASSERT_IMP(a_emit_slot, emit, slot_free, "result loaded over an untaken result")
    `SOSF_ASSERT_IMP(a_done_last, out_valid_reg && out_done_reg, out_last_reg, "scan end not last result")
    `SOSF_ASSERT_NXT(a_flush_hold, (state_reg == S_FLUSH) && !slot_free,
                     (state_reg == S_FLUSH) && $stable(fill_reg), "flush advanced while stalled")

endmodule

### bench/tb_scan_outlier_segment_filter_unit.sv
// Self-checking regression bench for the scan outlier and short-segment filter.
module tb_scan_outlier_segment_filter_unit;
    import sosf_pkg::*;

    localparam int PEND_DEPTH    = PENDING_DEPTH_DEF;
    localparam int IDLE_PCT      = 21;
    localparam int STALL_CYCLES  = 400;
    localparam int SETTLE_CYCLES = 12;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int REPORT_LINES  = 20;
    localparam logic [WIN_W-1:0] SCAN_TOP = WIN_W'(MAX_SCAN_POINTS_DEF - 1);

    typedef struct packed {
        logic [RANGE_W-1:0] mm;
        logic               fin;
    } sample_t;

    typedef struct packed {
        logic [RANGE_W-1:0] mm;
        logic               ok;
        logic               last;
        logic               done;
        logic               ovf;
    } released_t;

    logic clk = 1'b0;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic pready;

    sosf_in_if  samples_if ();
    sosf_out_if results_if ();

    scan_outlier_segment_filter_unit #(
        .PENDING_DEPTH   (PEND_DEPTH),
        .MAX_SCAN_POINTS (MAX_SCAN_POINTS_DEF)
    ) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples_if.sink),
        .results (results_if.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Stimulus and bookkeeping
    sample_t     sample_q[$];
    released_t   awaited_q[$];
    int          items_queued   = 0;
    int          items_accepted = 0;
    int          phase_items    = 0;
    int          mismatches     = 0;
    int          cycles         = 0;
    bit          calm           = 1'b0;
    bit          stall_arm      = 1'b0;
    bit          stall_used     = 1'b0;
    int          hold_left      = 0;
    sample_t     next_sample;

    // Filter state mirror
    cfg_t               cfg;
    logic [RANGE_W-1:0] held_mm;
    bit                 held_vld;
    logic [COUNT_W-1:0] seg_cnt;
    pend_entry_t        seg_pend_q[$];
    logic [WIN_W-1:0]   scan_idx;
    released_t          step_rels[$];

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= REPORT_LINES)
            $display("%0t mismatch: %s", $time, what);
    endtask

    // ---------------------------------------------------------------- filter mirror
    function automatic bit in_limits(input logic [RANGE_W-1:0] v);
        return v >= cfg.range_min_mm && v <= cfg.range_max_mm;
    endfunction

    task automatic put_release(input logic [RANGE_W-1:0] mm, input logic ok, input logic ovf);
        released_t r;
        r = '{mm: mm, ok: ok, last: 1'b0, done: 1'b0, ovf: ovf};
        step_rels.push_back(r);
    endtask

    // Store one judged sample; a full buffer gives up its oldest entry first
    task automatic store_pending(input logic [RANGE_W-1:0] mm, input logic ok);
        pend_entry_t e;
        if (seg_pend_q.size() >= PEND_DEPTH)
        begin
            e = seg_pend_q.pop_front();
            put_release(e.range_mm, e.ok, 1'b1);
        end
        e.ok       = ok;
        e.range_mm = mm;
        seg_pend_q.push_back(e);
    endtask

    task automatic drain_pending(input bit keep);
        foreach (seg_pend_q[i])
            put_release(seg_pend_q[i].range_mm, keep ? seg_pend_q[i].ok : 1'b0, 1'b0);
        seg_pend_q.delete();
    endtask

    // Judge the held sample against its raw successor
    task automatic judge_held(input logic [RANGE_W-1:0] nxt);
        logic [RANGE_W-1:0] gap;
        if (!in_limits(held_mm))
        begin
            store_pending(held_mm, 1'b0);
        end
        else
        begin
            store_pending(held_mm, 1'b1);
            gap = (held_mm > nxt) ? held_mm - nxt : nxt - held_mm;
            if (gap <= cfg.jump_threshold_mm)
            begin
                if (seg_cnt < COUNT_MAX)
                    seg_cnt++;
            end
            else if (seg_cnt < cfg.min_segment_len)
            begin
                drain_pending(1'b0);
                seg_cnt = '0;
            end
            else
            begin
                drain_pending(1'b1);
                seg_cnt = COUNT_W'(1);
            end
        end
    endtask

    // Close the scan: last sample is range-checked only, final segment kept
    task automatic close_scan();
        released_t r;
        if (held_vld)
            store_pending(held_mm, in_limits(held_mm));
        drain_pending(1'b1);
        if (step_rels.size() > 0)
        begin
            r      = step_rels.pop_back();
            r.done = 1'b1;
            step_rels.push_back(r);
        end
        held_vld = 1'b0;
        held_mm  = '0;
        seg_cnt  = '0;
        scan_idx = '0;
    endtask

    task automatic filter_sample(input logic [RANGE_W-1:0] mm, input logic fin);
        logic [WIN_W-1:0] idx;
        bit               kept;
        released_t        r;
        idx  = scan_idx;
        kept = idx >= cfg.window_first && idx <= cfg.window_last;
        step_rels.delete();
        if (scan_idx < SCAN_TOP)
            scan_idx++;
        if (kept)
        begin
            if (held_vld)
                judge_held(mm);
            held_mm  = mm;
            held_vld = 1'b1;
            if (fin || idx == cfg.window_last)
                close_scan();
        end
        else if (fin)
        begin
            close_scan();
        end
        if (step_rels.size() > 0)
        begin
            r      = step_rels.pop_back();
            r.last = 1'b1;
            step_rels.push_back(r);
        end
        foreach (step_rels[i])
            awaited_q.push_back(step_rels[i]);
    endtask

    // ---------------------------------------------------------------- sample driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            samples_if.valid    <= 1'b0;
            samples_if.range_mm <= '0;
            samples_if.scan_end <= 1'b0;
        end
        else
        begin
            if (samples_if.valid && samples_if.ready)
            begin
                filter_sample(samples_if.range_mm, samples_if.scan_end);
                items_accepted++;
            end
            if (!samples_if.valid || samples_if.ready)
            begin
                if (sample_q.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT))
                begin
                    next_sample = sample_q.pop_front();
                    samples_if.valid    <= 1'b1;
                    samples_if.range_mm <= next_sample.mm;
                    samples_if.scan_end <= next_sample.fin;
                end
                else
                begin
                    samples_if.valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------- result monitor
    task automatic check_release();
        released_t want;
        if (awaited_q.size() == 0)
        begin
            report_mismatch($sformatf("unexpected transfer, range %0d",
                                      results_if.out_range_mm));
        end
        else
        begin
            want = awaited_q.pop_front();
            if (results_if.out_range_mm !== want.mm)
                report_mismatch($sformatf("out_range_mm %0d, want %0d",
                                          results_if.out_range_mm, want.mm));
            if (results_if.sample_ok !== want.ok)
                report_mismatch($sformatf("sample_ok %b, want %b (range %0d)",
                                          results_if.sample_ok, want.ok, want.mm));
            if (results_if.run_last !== want.last)
                report_mismatch($sformatf("run_last %b, want %b (range %0d)",
                                          results_if.run_last, want.last, want.mm));
            if (results_if.scan_done !== want.done)
                report_mismatch($sformatf("scan_done %b, want %b (range %0d)",
                                          results_if.scan_done, want.done, want.mm));
            if (results_if.overflow !== want.ovf)
                report_mismatch($sformatf("overflow %b, want %b (range %0d)",
                                          results_if.overflow, want.ovf, want.mm));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            results_if.ready <= 1'b0;
            hold_left = 0;
        end
        else
        begin
            if (results_if.valid && results_if.ready)
                check_release();
            // one long hold-off so the block backs up into its input
            if (stall_arm && !stall_used)
            begin
                stall_used = 1'b1;
                hold_left  = STALL_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                results_if.ready <= 1'b0;
            end
            else
            begin
                results_if.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // Run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("scan_outlier_segment_filter_unit regression: fail");
            $finish;
        end
    end

    // ---------------------------------------------------------------- register port
    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
        logic [CFG_DATA_W-1:0] keep_bits;
        case (idx)
            CFG_MIN_SEG:   keep_bits = 32'h1F;
            CFG_WIN_FIRST: keep_bits = 32'hFFF;
            CFG_WIN_LAST:  keep_bits = 32'hFFF;
            default:       keep_bits = 32'hFFFF;
        endcase
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        case (idx)
            CFG_RANGE_MIN: cfg.range_min_mm      = val[RANGE_W-1:0];
            CFG_RANGE_MAX: cfg.range_max_mm      = val[RANGE_W-1:0];
            CFG_JUMP_THR:  cfg.jump_threshold_mm = val[RANGE_W-1:0];
            CFG_MIN_SEG:   cfg.min_segment_len   = val[LEN_W-1:0];
            CFG_WIN_FIRST: cfg.window_first      = val[WIN_W-1:0];
            CFG_WIN_LAST:  cfg.window_last       = val[WIN_W-1:0];
            default: ;
        endcase
        // read it back
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if ((prdata & keep_bits) !== (val & keep_bits))
            report_mismatch($sformatf("register %s reads %0h, want %0h",
                                      idx.name(), prdata & keep_bits, val & keep_bits));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_all(input int rmin, input int rmax, input int thr, input int seg_len,
                           input int first, input int lst);
        write_reg(CFG_RANGE_MIN, rmin);
        write_reg(CFG_RANGE_MAX, rmax);
        write_reg(CFG_JUMP_THR, thr);
        write_reg(CFG_MIN_SEG, seg_len);
        write_reg(CFG_WIN_FIRST, first);
        write_reg(CFG_WIN_LAST, lst);
    endtask

    // ---------------------------------------------------------------- stimulus
    task automatic queue_sample(input int mm, input bit fin);
        sample_t s;
        s.mm  = mm[RANGE_W-1:0];
        s.fin = fin;
        sample_q.push_back(s);
        items_queued++;
    endtask

    // Hold the sender until every transfer is back, then let the block go quiet
    task automatic settle();
        while (items_accepted != items_queued || awaited_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // A scan: mostly smooth runs, with jumps, outliers and repeats mixed in
    task automatic queue_scan(input int len);
        int unsigned cur;
        int unsigned step_max;
        int unsigned pick;
        int unsigned val;
        cur      = $urandom_range(65535);
        step_max = (cfg.jump_threshold_mm > 3000) ? 3000 : cfg.jump_threshold_mm;
        for (int i = 0; i < len; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 65)
            begin
                if ($urandom_range(1))
                    cur = (cur + $urandom_range(step_max)) & 16'hFFFF;
                else
                    cur = (cur - $urandom_range(step_max)) & 16'hFFFF;
                val = cur;
            end
            else if (pick < 80)
            begin
                cur = $urandom_range(65535);
                val = cur;
            end
            else if (pick < 90)
            begin
                case ($urandom_range(3))
                    0:       val = 0;
                    1:       val = 65535;
                    2:       val = (cfg.range_min_mm - 1) & 16'hFFFF;
                    default: val = (cfg.range_max_mm + 1) & 16'hFFFF;
                endcase
            end
            else
            begin
                val = cur;
            end
            queue_sample(val, (i == len - 1) && ($urandom_range(9) != 0));
            phase_items++;
        end
    endtask

    task automatic queue_burst(input int n_items);
        phase_items = 0;
        while (phase_items < n_items)
        begin
            if ($urandom_range(99) < 12)
            begin
                repeat ($urandom_range(1, 3))
                begin
                    queue_sample($urandom_range(65535), $urandom_range(9) == 0);
                    phase_items++;
                end
            end
            else if ($urandom_range(99) < 15)
            begin
                queue_scan($urandom_range(33, 45));
            end
            else
            begin
                queue_scan($urandom_range(2, 14));
            end
        end
    endtask

    initial
    begin
        rst_n               = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        cfg = '{range_min_mm: RANGE_MIN_RST, range_max_mm: RANGE_MAX_RST,
                jump_threshold_mm: JUMP_THR_RST, min_segment_len: MIN_SEG_RST,
                window_first: WIN_FIRST_RST, window_last: WIN_LAST_RST};
        held_mm  = '0;
        held_vld = 1'b0;
        seg_cnt  = '0;
        scan_idx = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Reset settings: short segment invalidated, long one kept, extremes of range
        queue_sample(0, 0);
        queue_sample(65535, 0);
        queue_sample(65535, 0);
        queue_sample(65500, 0);
        queue_sample(65450, 0);
        queue_sample(65400, 0);
        queue_sample(65400, 0);
        queue_sample(1000, 0);
        queue_sample(1000, 0);
        queue_sample(1050, 1);
        settle();

        // Range limits at their edges, zero threshold, zero minimum length
        set_all(1000, 60000, 0, 0, 0, 4095);
        queue_sample(999, 0);
        queue_sample(1000, 0);
        queue_sample(1000, 0);
        queue_sample(60000, 0);
        queue_sample(60001, 0);
        queue_sample(60000, 1);
        settle();

        // Index window: empty scan end, end at the last index, end on a dropped sample
        set_all(0, 65535, 65535, 31, 2, 6);
        queue_sample(5, 0);
        queue_sample(7, 1);
        for (int i = 0; i < 7; i++)
            queue_sample(100 * (i + 1), 0);
        for (int i = 0; i < 4; i++)
            queue_sample(300 + i, 0);
        settle();
        write_reg(CFG_WIN_LAST, 3);
        queue_sample(123, 1);
        settle();

        // Crossed limits, one-sample scans
        set_all(65535, 0, 0, 0, 0, 0);
        queue_sample(0, 0);
        queue_sample(40000, 1);
        queue_sample(65535, 0);
        settle();

        // Random scans, no idling on either side
        calm = 1'b1;
        set_all($urandom_range(0, 2000), $urandom_range(50000, 65535),
                $urandom_range(20, 400), $urandom_range(0, 8), 0, 4095);
        queue_burst(46);
        settle();
        calm = 1'b0;

        // Short windows, with a long hold-off on the result side
        set_all($urandom_range(0, 2000), $urandom_range(50000, 65535),
                $urandom_range(20, 400), $urandom_range(0, 8),
                $urandom_range(0, 3), $urandom_range(8, 40));
        queue_burst(46);
        stall_arm = 1'b1;
        settle();

        // Widest threshold: long segments run the buffer into overflow
        set_all(0, 65535, 65535, $urandom_range(0, 31), 0, 4095);
        queue_burst(46);
        settle();

        // Everything loose, limits may cross
        set_all($urandom_range(0, 30000), $urandom_range(20000, 65535),
                $urandom_range(0, 1500), $urandom_range(0, 31),
                $urandom_range(0, 2), $urandom_range(20, 4095));
        queue_burst(46);
        settle();

        if (awaited_q.size() != 0)
            report_mismatch($sformatf("%0d transfers never arrived", awaited_q.size()));
        if (mismatches == 0)
            $display("scan_outlier_segment_filter_unit regression: pass");
        else
            $display("scan_outlier_segment_filter_unit regression: fail");
        $finish;
    end

endmodule
